// ===== sv/assert_macros.svh =====
// Shared assertion macros for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define SDI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SDI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sdi_pkg.sv =====
package sdi_pkg;

  localparam int CharW = 8;
  localparam int ValueW = 32;
  localparam int ProdW = ValueW + 3;

  // Magnitude saturates one above the largest negative magnitude.
  localparam logic [ValueW-1:0] MagCap = 32'h8000_0001;
  localparam logic [ValueW-1:0] NegMax = 32'h8000_0000;
  localparam logic [ValueW-1:0] PosMax = 32'h7FFF_FFFF;

  localparam logic [CharW-1:0] ChTerm  = 8'd0;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChZero  = 8'd48;
  localparam logic [CharW-1:0] ChNine  = 8'd57;
  localparam logic [CharW-1:0] ChPlus  = 8'd43;
  localparam logic [CharW-1:0] ChMinus = 8'd45;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_TRAIL = 2'd2,
    PH_ERR   = 2'd3
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] code;
  } char_stage_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

// ===== sv/sdi_char_if.sv =====
interface sdi_char_if;
  import sdi_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

// ===== sv/sdi_result_if.sv =====
interface sdi_result_if;
  import sdi_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic                     error;

  modport source (output valid, output value, output error, input ready);
  modport sink (input valid, input value, input error, output ready);
endinterface

// ===== sv/sdi_in_stage.sv =====
module sdi_in_stage (
  input  logic                clk,
  input  logic                rst,
  sdi_char_if.sink            chars,
  input  logic                consume,
  output sdi_pkg::char_stage_t stage
);
  import sdi_pkg::*;

  logic             valid;
  logic [CharW-1:0] code;

  // The register can take a new item whenever its current one moves on.
  assign chars.ready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.ready) begin
      valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      code <= chars.char_code;
    end
  end

  assign stage.valid = valid;
  assign stage.code  = code;
endmodule

// ===== sv/sdi_parse.sv =====
module sdi_parse (
  input  logic                clk,
  input  logic                rst,
  input  sdi_pkg::char_stage_t stage,
  output logic                consume,
  sdi_result_if.source        results
);
  import sdi_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic                negative;
  logic                negative_next;
  logic [ValueW-1:0]   magnitude;
  logic [ValueW-1:0]   magnitude_next;
  logic                out_valid;
  logic [ValueW-1:0]   out_value;
  logic                out_error;

  logic                is_term;
  logic                out_free;
  logic                c_space;
  logic                c_digit;
  logic                c_sign;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   mag_digit;
  logic                term_error;
  logic [ValueW-1:0]   term_value;

  assign is_term  = (stage.code == ChTerm);
  assign out_free = !out_valid || results.ready;
  // Only a terminator has to wait for room in the result register.
  assign consume  = stage.valid && (!is_term || out_free);

  assign c_space = is_space(stage.code);
  assign c_digit = is_digit(stage.code);
  assign c_sign  = (stage.code == ChPlus) || (stage.code == ChMinus);

  // Times ten as two shifts and an add, then the saturation cap.
  assign prod = ({3'b000, magnitude} << 3) + ({3'b000, magnitude} << 1)
              + ProdW'(stage.code - ChZero);
  assign mag_digit = (prod > ProdW'(MagCap)) ? MagCap : prod[ValueW-1:0];

  assign term_error = (phase == PH_ERR)
                   || (negative ? (magnitude > NegMax) : (magnitude > PosMax));
  assign term_value = term_error ? '0
                    : (negative ? (~magnitude + 1'b1) : magnitude);

  always_comb begin
    phase_next     = phase;
    negative_next  = negative;
    magnitude_next = magnitude;
    if (is_term) begin
      phase_next     = PH_LEAD;
      negative_next  = 1'b0;
      magnitude_next = '0;
    end else begin
      case (phase)
        PH_LEAD: begin
          if (c_space) begin
            phase_next = PH_LEAD;
          end else if (c_sign) begin
            negative_next = (stage.code == ChMinus);
            phase_next    = PH_DIGIT;
          end else if (c_digit) begin
            magnitude_next = mag_digit;
            phase_next     = PH_DIGIT;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_DIGIT: begin
          if (c_digit) begin
            magnitude_next = mag_digit;
          end else if (c_space) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_ERR;
          end
        end
        PH_TRAIL: begin
          if (!c_space) begin
            phase_next = PH_ERR;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      negative  <= 1'b0;
      magnitude <= '0;
    end else if (consume) begin
      phase     <= phase_next;
      negative  <= negative_next;
      magnitude <= magnitude_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && is_term) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && is_term) begin
      out_value <= term_value;
      out_error <= term_error;
    end
  end

  assign results.valid = out_valid;
  assign results.value = out_value;
  assign results.error = out_error;
endmodule

// ===== sv/strict_decimal_to_int32_unit.sv =====
// Channel   Direction  Payload                          Handshake
// chars     in         char_code[7:0]                   valid/ready
// results   out        value[31:0] signed, error        valid/ready
//
// Each item waits in the input register until the parser takes it, and the parser updates
// its state as it takes the item. A string terminator's result is registered when the
// parser takes the terminator; other items give none. Reset is synchronous and empties
// both registers. One item is taken per cycle unless a terminator awaits a stalled result.
// A stalled result holds back only a terminator, and the items queued behind it.
module strict_decimal_to_int32_unit (
  input logic          clk,
  input logic          rst,
  sdi_char_if.sink     chars,
  sdi_result_if.source results
);
  import sdi_pkg::*;

  char_stage_t stage;
  logic        consume;

  sdi_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .consume (consume),
    .stage   (stage)
  );

  sdi_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .consume (consume),
    .results (results)
  );
endmodule

// ===== sv/sdi_chk.sv =====
`include "assert_macros.svh"

module sdi_chk (
  input logic        clk,
  input logic        rst,
  input logic        chars_ready,
  input logic        results_valid,
  input logic        results_ready,
  input logic [31:0] results_value,
  input logic        results_error
);

  // A flagged result always carries a zero value.
  `SDI_ASSERT(a_err_zero, clk, rst, results_valid && results_error |-> results_value == 32'd0, "error result with nonzero value")

  // A result waiting on the sink keeps its payload.
  `SDI_ASSERT(a_hold, clk, rst, results_valid && !results_ready |=> results_valid && $stable(results_value) && $stable(results_error), "stalled result changed")

  // Reset leaves no result pending.
  `SDI_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !results_valid, "result valid after reset")

  // Reset empties the input register, so an item can be taken right away.
  `SDI_ASSERT_ALWAYS(a_rst_in, clk, rst |=> chars_ready, "input not ready after reset")
endmodule

bind strict_decimal_to_int32_unit sdi_chk u_sdi_chk (
  .clk           (clk),
  .rst           (rst),
  .chars_ready   (chars.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_value (results.value),
  .results_error (results.error)
);
